/* rtl/core/per_client_fixed_window_limiter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the per-client fixed window limiter
// Clocked implication helpers, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_FIXED_WINDOW_LIMITER_MACROS_SVH
`define PER_CLIENT_FIXED_WINDOW_LIMITER_MACROS_SVH

// Same-cycle implication
`define PCFWL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pcfwl same-cycle check failed");

// Next-cycle implication
`define PCFWL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pcfwl next-cycle check failed");

`endif

/* rtl/core/pcfwl_pkg.sv */
// ----------------------------------------------------------------------------
// pcfwl_pkg
// Shared types and constants of the per-client fixed window limiter.
// ----------------------------------------------------------------------------
package pcfwl_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ID_W       = 8;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned WTICKS_W   = 32;
  localparam int unsigned MAXREQ_W   = 16;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Saturation point of the per-window count
  localparam logic [COUNT_W-1:0] COUNT_SAT = 17'h10000;

  // Register reset values
  localparam logic [WTICKS_W-1:0] WTICKS_RST = 32'd1000;
  localparam logic [MAXREQ_W-1:0] MAXREQ_RST = 16'd10;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 4'd1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // Table access controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

endpackage

/* rtl/core/pcfwl_table.sv */
// ----------------------------------------------------------------------------
// pcfwl_table
// Per-client state store: window start and count in a synchronous RAM with a
// registered read port, entry valid bits in flops cleared by reset.
// ----------------------------------------------------------------------------
module pcfwl_table #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned IDX_W     = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcfwl_pkg::tbl_ctrl_t             ctrl_i,
  input  logic [IDX_W-1:0]                 rd_idx_i,
  input  logic [IDX_W-1:0]                 wr_idx_i,
  input  logic [TIME_BITS-1:0]             wr_start_i,
  input  logic [pcfwl_pkg::COUNT_W-1:0]    wr_count_i,
  output logic                             rd_valid_o,
  output logic [TIME_BITS-1:0]             rd_start_o,
  output logic [pcfwl_pkg::COUNT_W-1:0]    rd_count_o
);

  logic [TIME_BITS-1:0]          start_mem [DEPTH];
  logic [pcfwl_pkg::COUNT_W-1:0] count_mem [DEPTH];
  logic [DEPTH-1:0]              valid_q;
  logic                          rd_valid_q;
  logic [TIME_BITS-1:0]          rd_start_q;
  logic [pcfwl_pkg::COUNT_W-1:0] rd_count_q;

  // RAM write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      start_mem[wr_idx_i] <= wr_start_i;
      count_mem[wr_idx_i] <= wr_count_i;
    end
    if (ctrl_i.rd_en) begin
      rd_start_q <= start_mem[rd_idx_i];
      rd_count_q <= count_mem[rd_idx_i];
    end
  end

  // Valid bits, set on first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_start_o = rd_start_q;
  assign rd_count_o = rd_count_q;

endmodule

/* rtl/core/pcfwl_update.sv */
// ----------------------------------------------------------------------------
// pcfwl_update
// Window check and count update for one looked-up entry.
// ----------------------------------------------------------------------------
module pcfwl_update #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              entry_valid_i,
  input  logic [TIME_BITS-1:0]              start_i,
  input  logic [pcfwl_pkg::COUNT_W-1:0]     count_i,
  input  logic [TIME_BITS-1:0]              now_i,
  input  logic [pcfwl_pkg::WTICKS_W-1:0]    window_ticks_i,
  input  logic [pcfwl_pkg::MAXREQ_W-1:0]    max_requests_i,
  output logic [TIME_BITS-1:0]              new_start_o,
  output logic [pcfwl_pkg::COUNT_W-1:0]     new_count_o,
  output logic                              allowed_o
);

  localparam int unsigned CMP_W =
    (TIME_BITS > pcfwl_pkg::WTICKS_W) ? TIME_BITS : pcfwl_pkg::WTICKS_W;

  logic [TIME_BITS-1:0]          base_start;
  logic [pcfwl_pkg::COUNT_W-1:0] base_count;
  logic [TIME_BITS-1:0]          elapsed;
  logic                          restart;
  logic [pcfwl_pkg::COUNT_W-1:0] cur_count;

  // A fresh entry opens at now with a zero count
  assign base_start = entry_valid_i ? start_i : now_i;
  assign base_count = entry_valid_i ? count_i : '0;

  // Modular elapsed time against the window length
  assign elapsed = now_i - base_start;
  assign restart = CMP_W'(elapsed) >= CMP_W'(window_ticks_i);

  assign cur_count   = restart ? '0 : base_count;
  assign new_start_o = restart ? now_i : base_start;

  // Saturating increment
  assign new_count_o = (cur_count == pcfwl_pkg::COUNT_SAT) ? cur_count
                                                            : cur_count + 1'b1;

  assign allowed_o = new_count_o <= {1'b0, max_requests_i};

endmodule

/* rtl/core/per_client_fixed_window_limiter.sv */
// ----------------------------------------------------------------------------
// per_client_fixed_window_limiter
// Counts requests per client in fixed time windows and admits up to a limit.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries client_id_i and the
//   current timestamp_i. One result beat per request leaves on the response
//   channel (out_valid_o/out_ready_i) with allowed_o and request_count_o,
//   in request order.
//   The config channel writes window_ticks (index 0) and max_requests
//   (index 1); it is always ready and should only be used while idle.
// Timing:
//   The table entry is read from the state RAM when a request is accepted;
//   in the lookup state the update is written back and the result is
//   registered once the output register is free. One request is handled
//   at a time: in_ready_o stays low in the lookup state, so no new request
//   is accepted until the last one has finished its read-modify-write.
// Reset:
//   All entry valid bits clear at once; registers return to 1000 and 10.
// Stalls:
//   A held result sits in the output register; the next request is still
//   accepted and read, then waits with in_ready_o low until the output
//   register frees up.
// ----------------------------------------------------------------------------
module per_client_fixed_window_limiter #(
  parameter int unsigned NUM_CLIENTS = 256,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pcfwl_pkg::ID_W-1:0]          client_id_i,
  input  logic [pcfwl_pkg::TS_W-1:0]          timestamp_i,
  // response channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                allowed_o,
  output logic [pcfwl_pkg::COUNT_W-1:0]       request_count_o,
  // config channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcfwl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcfwl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned ID_SPAN = 1 << pcfwl_pkg::ID_W;
  localparam int unsigned DEPTH   = (NUM_CLIENTS < ID_SPAN) ? NUM_CLIENTS : ID_SPAN;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pcfwl_pkg::state_e                 state_q, state_d;
  pcfwl_pkg::tbl_ctrl_t              tbl_ctrl;

  logic [pcfwl_pkg::WTICKS_W-1:0]    window_ticks_q;
  logic [pcfwl_pkg::MAXREQ_W-1:0]    max_requests_q;

  logic [IDX_W-1:0]                  idx_q;
  logic [TIME_BITS-1:0]              now_q;
  logic                              in_range_q;

  logic                              out_valid_q;
  logic                              out_allowed_q;
  logic [pcfwl_pkg::COUNT_W-1:0]     out_count_q;

  logic                              in_fire;
  logic                              out_free;
  logic                              finish;
  logic                              in_range;
  logic [IDX_W-1:0]                  in_idx;

  logic                              rd_valid;
  logic [TIME_BITS-1:0]              rd_start;
  logic [pcfwl_pkg::COUNT_W-1:0]     rd_count;
  logic [TIME_BITS-1:0]              new_start;
  logic [pcfwl_pkg::COUNT_W-1:0]     new_count;
  logic                              upd_allowed;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;
  assign finish   = (state_q == pcfwl_pkg::ST_LOOKUP) & out_free;
  assign in_range = 32'(client_id_i) < NUM_CLIENTS;
  assign in_idx   = client_id_i[IDX_W-1:0];

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q <= pcfwl_pkg::WTICKS_RST;
      max_requests_q <= pcfwl_pkg::MAXREQ_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pcfwl_pkg::REG_WINDOW_TICKS: window_ticks_q <= cfg_data_i;
        pcfwl_pkg::REG_MAX_REQUESTS: max_requests_q <= cfg_data_i[pcfwl_pkg::MAXREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcfwl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and table controls
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    tbl_ctrl.rd_en = 1'b0;
    tbl_ctrl.wr_en = 1'b0;
    unique case (state_q)
      pcfwl_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        tbl_ctrl.rd_en = in_valid_i & in_range;
        if (in_valid_i) begin
          state_d = pcfwl_pkg::ST_LOOKUP;
        end
      end
      pcfwl_pkg::ST_LOOKUP: begin
        tbl_ctrl.wr_en = finish & in_range_q;
        if (finish) begin
          state_d = pcfwl_pkg::ST_IDLE;
        end
      end
      default: state_d = pcfwl_pkg::ST_IDLE;
    endcase
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q      <= in_idx;
      now_q      <= TIME_BITS'(timestamp_i);
      in_range_q <= in_range;
    end
  end

  pcfwl_table #(
    .DEPTH     (DEPTH),
    .IDX_W     (IDX_W),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tbl_ctrl),
    .rd_idx_i   (in_idx),
    .wr_idx_i   (idx_q),
    .wr_start_i (new_start),
    .wr_count_i (new_count),
    .rd_valid_o (rd_valid),
    .rd_start_o (rd_start),
    .rd_count_o (rd_count)
  );

  pcfwl_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .entry_valid_i  (rd_valid),
    .start_i        (rd_start),
    .count_i        (rd_count),
    .now_i          (now_q),
    .window_ticks_i (window_ticks_q),
    .max_requests_i (max_requests_q),
    .new_start_o    (new_start),
    .new_count_o    (new_count),
    .allowed_o      (upd_allowed)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_allowed_q <= in_range_q & upd_allowed;
      out_count_q   <= in_range_q ? new_count : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign allowed_o       = out_allowed_q;
  assign request_count_o = out_count_q;

endmodule

/* rtl/core/pcfwl_checker.sv */
// ----------------------------------------------------------------------------
// pcfwl_checker
// Port-level checks of the per-client fixed window limiter, bound to the top.
// ----------------------------------------------------------------------------
`include "per_client_fixed_window_limiter_macros.svh"

module pcfwl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            allowed_o,
  input logic [pcfwl_pkg::COUNT_W-1:0]   request_count_o
);

  // A stalled result beat stays
  `PCFWL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // One request in flight: no accept right after an accept
  `PCFWL_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // An admitted request has counted itself
  `PCFWL_ASSERT_NOW(a_allowed_count, clk_i, rst_ni, out_valid_o && allowed_o,
                    request_count_o != '0)

  // A saturated count is never admitted
  `PCFWL_ASSERT_NOW(a_sat_reject, clk_i, rst_ni, out_valid_o && request_count_o[16],
                    !allowed_o && (request_count_o[15:0] == 16'd0))

endmodule

bind per_client_fixed_window_limiter pcfwl_checker u_pcfwl_checker (.*);
